/* rtl/core/perm_unrank_simple_check_assert.svh */
// assertion macros shared by the permutation unrank and check block
`ifndef PERM_UNRANK_SIMPLE_CHECK_ASSERT_SVH
`define PERM_UNRANK_SIMPLE_CHECK_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PUSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PUSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pusc_pkg.sv */
// shared types, constants and elaboration helpers for the permutation unrank block
package pusc_pkg;

   localparam int RANK_W   = 22;
   localparam int VAL_W    = 4;
   localparam int PACK_NIB = 10;
   localparam int PACK_W   = PACK_NIB * VAL_W;

   typedef logic [RANK_W-1:0] rank_type;
   typedef logic [RANK_W:0]   thr_type;
   typedef logic [VAL_W-1:0]  val_type;

   // value codes that never occur in a permutation of 1..n
   localparam val_type VAL_NONE = val_type'(0);
   localparam val_type VAL_TOP  = val_type'(15);

   localparam longint unsigned RANK_SPAN = 64'd1 << RANK_W;
   // threshold that no rank reaches
   localparam thr_type THR_SAT = {1'b1, {RANK_W{1'b0}}};

   function automatic longint unsigned fact_of(input int n);
      longint unsigned f;
      f = 64'd1;
      for (int t = 2; t <= n; t++) begin
         f = f * 64'(t);
      end
      return f;
   endfunction

   // number of restoring steps that bring any rank below n!
   function automatic int mod_steps(input int n);
      longint unsigned f;
      int s;
      f = fact_of(n);
      s = 0;
      for (int i = 0; i < RANK_W; i++) begin
         if ((f << s) < RANK_SPAN) begin
            s++;
         end
      end
      return s;
   endfunction

   // n! scaled by 2^sh, known to fit the rank width
   function automatic rank_type mod_sub(input int n, input int sh);
      return rank_type'(fact_of(n) << sh);
   endfunction

   // m times (n-1-k)!, saturated when the digit cannot reach m
   function automatic thr_type dig_thr(input int n, input int k, input int m);
      longint unsigned f;
      longint unsigned p;
      f = fact_of(n - 1 - k);
      p = f * 64'(m);
      if ((m > n - 1 - k) || (p >= RANK_SPAN)) begin
         return THR_SAT;
      end
      return thr_type'(p);
   endfunction

endpackage

/* rtl/core/pusc_mod_cell.sv */
// restoring-subtract cell that removes one scaled multiple of n! from the rank
module pusc_mod_cell
   import pusc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_stall,
   input  rank_type up_rank,
   input  rank_type sub_val,
   output logic     dn_valid,
   input  logic     dn_stall,
   output rank_type dn_rank
);

   logic     valid_ff;
   logic     valid_in;
   logic     load;
   rank_type rank_ff;
   rank_type rank_in;

   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_comb begin
      rank_in = (up_rank >= sub_val) ? (up_rank - sub_val) : up_rank;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rank_ff <= rank_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rank  = rank_ff;

endmodule

/* rtl/core/pusc_digit_cell.sv */
// factorial-base digit cell: one digit out, remainder on to the next cell
module pusc_digit_cell
   import pusc_pkg::*;
#(
   parameter int PERM_LEN = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_stall,
   input  rank_type                           up_rem,
   input  logic [PERM_LEN-1:0][VAL_W-1:0]     up_digs,
   input  logic [PERM_LEN-2:0][RANK_W:0]      thr,
   output logic                               dn_valid,
   input  logic                               dn_stall,
   output rank_type                           dn_rem,
   output logic [PERM_LEN-1:0][VAL_W-1:0]     dn_digs
);

   logic                           valid_ff;
   logic                           valid_in;
   logic                           load;
   rank_type                       rem_ff;
   rank_type                       rem_in;
   logic [PERM_LEN-1:0][VAL_W-1:0] digs_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0] digs_in;
   val_type                        quot;
   val_type                        dig_val;
   rank_type                       sub;

   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // thresholds rise with m, so the last one reached gives the quotient
   always_comb begin
      quot = VAL_NONE;
      sub  = '0;
      for (int m = 0; m < PERM_LEN - 1; m++) begin
         if ({1'b0, up_rem} >= thr[m]) begin
            quot = val_type'(m + 1);
            sub  = thr[m][RANK_W-1:0];
         end
      end
      dig_val = quot + val_type'(1);
      rem_in  = up_rem - sub;
      // new digit enters at the top, earlier ones move down one place
      digs_in = {dig_val, up_digs[PERM_LEN-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         digs_ff <= digs_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_digs  = digs_ff;

endmodule

/* rtl/core/pusc_adjust_cell.sv */
// readjust cell: bumps each value past one earlier digit, compare row slides up
module pusc_adjust_cell
   import pusc_pkg::*;
#(
   parameter int PERM_LEN = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_valid,
   output logic                           up_stall,
   input  logic [PERM_LEN-1:0][VAL_W-1:0] up_vals,
   input  logic [PERM_LEN-1:0][VAL_W-1:0] up_cmps,
   output logic                           dn_valid,
   input  logic                           dn_stall,
   output logic [PERM_LEN-1:0][VAL_W-1:0] dn_vals,
   output logic [PERM_LEN-1:0][VAL_W-1:0] dn_cmps
);

   logic                           valid_ff;
   logic                           valid_in;
   logic                           load;
   logic [PERM_LEN-1:0][VAL_W-1:0] vals_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0] vals_in;
   logic [PERM_LEN-1:0][VAL_W-1:0] cmps_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0] cmps_in;

   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_comb begin
      for (int k = 0; k < PERM_LEN; k++) begin
         vals_in[k] = (up_cmps[k] <= up_vals[k]) ? (up_vals[k] + val_type'(1)) : up_vals[k];
      end
      // next cell compares against the digit one place further left
      cmps_in = {up_cmps[PERM_LEN-2:0], VAL_TOP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vals_ff <= vals_in;
         cmps_ff <= cmps_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vals  = vals_ff;
   assign dn_cmps  = cmps_ff;

endmodule

/* rtl/core/pusc_check_cell.sv */
// window cell: grows every window by one position and tests interval splits
module pusc_check_cell
   import pusc_pkg::*;
#(
   parameter int PERM_LEN = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_stall,
   input  logic [PERM_LEN-1:0][VAL_W-1:0]    up_perm,
   input  logic [PERM_LEN-1:0][VAL_W-1:0]    up_q,
   input  logic [PERM_LEN-1:0][VAL_W-1:0]    up_mn,
   input  logic [PERM_LEN-1:0][VAL_W-1:0]    up_mx,
   input  logic [PERM_LEN-1:0][PERM_LEN-1:0] up_pre,
   input  logic [PERM_LEN-1:0][PERM_LEN-1:0] up_sr,
   input  val_type                           up_len,
   input  logic                              up_bad,
   output logic                              dn_valid,
   input  logic                              dn_stall,
   output logic [PERM_LEN-1:0][VAL_W-1:0]    dn_perm,
   output logic [PERM_LEN-1:0][VAL_W-1:0]    dn_q,
   output logic [PERM_LEN-1:0][VAL_W-1:0]    dn_mn,
   output logic [PERM_LEN-1:0][VAL_W-1:0]    dn_mx,
   output logic [PERM_LEN-1:0][PERM_LEN-1:0] dn_pre,
   output logic [PERM_LEN-1:0][PERM_LEN-1:0] dn_sr,
   output val_type                           dn_len,
   output logic                              dn_bad
);

   logic                              valid_ff;
   logic                              valid_in;
   logic                              load;
   logic [PERM_LEN-1:0][VAL_W-1:0]    perm_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0]    q_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0]    q_in;
   logic [PERM_LEN-1:0][VAL_W-1:0]    mn_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0]    mn_in;
   logic [PERM_LEN-1:0][VAL_W-1:0]    mx_ff;
   logic [PERM_LEN-1:0][VAL_W-1:0]    mx_in;
   logic [PERM_LEN-1:0][PERM_LEN-1:0] pre_ff;
   logic [PERM_LEN-1:0][PERM_LEN-1:0] pre_in;
   logic [PERM_LEN-1:0][PERM_LEN-1:0] sr_ff;
   logic [PERM_LEN-1:0][PERM_LEN-1:0] sr_in;
   val_type                           len_ff;
   val_type                           len_in;
   logic                              bad_ff;
   logic                              bad_in;
   logic [PERM_LEN-1:0]               ivl;
   logic [PERM_LEN-1:0]               hit_vec;
   logic [PERM_LEN-1:0]               len_oh;

   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_comb begin
      len_oh = PERM_LEN'(1) << up_len;
      for (int lo = 0; lo < PERM_LEN; lo++) begin
         // empty q means the window runs past the end
         mn_in[lo] = ((up_q[lo] != VAL_NONE) && (up_q[lo] < up_mn[lo])) ? up_q[lo] : up_mn[lo];
         mx_in[lo] = ((up_q[lo] != VAL_NONE) && (up_q[lo] > up_mx[lo])) ? up_q[lo] : up_mx[lo];
         ivl[lo]   = (up_q[lo] != VAL_NONE) && ((mx_in[lo] - mn_in[lo]) == up_len);
         // prefix and suffix interval masks line up on the split point
         hit_vec[lo] = ivl[lo] && (|(up_pre[lo] & up_sr[lo]));
         pre_in[lo]  = up_pre[lo] | (ivl[lo] ? len_oh : '0);
      end
      for (int lo = 0; lo < PERM_LEN - 1; lo++) begin
         sr_in[lo] = (up_sr[lo+1] << 1) | PERM_LEN'(ivl[lo+1]);
         q_in[lo]  = up_q[lo+1];
      end
      sr_in[PERM_LEN-1] = '0;
      q_in[PERM_LEN-1]  = VAL_NONE;
      len_in = up_len + val_type'(1);
      bad_in = up_bad | (|hit_vec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         perm_ff <= up_perm;
         q_ff    <= q_in;
         mn_ff   <= mn_in;
         mx_ff   <= mx_in;
         pre_ff  <= pre_in;
         sr_ff   <= sr_in;
         len_ff  <= len_in;
         bad_ff  <= bad_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_perm  = perm_ff;
   assign dn_q     = q_ff;
   assign dn_mn    = mn_ff;
   assign dn_mx    = mx_ff;
   assign dn_pre   = pre_ff;
   assign dn_sr    = sr_ff;
   assign dn_len   = len_ff;
   assign dn_bad   = bad_ff;

endmodule

/* rtl/core/perm_unrank_simple_check.sv */
// top level of the permutation unrank and simplicity check block
//
// a rank beat on req_ becomes the rank-th permutation of 1..PERM_LEN in
// lexicographic order plus a flag that is 1 when no window of two or more
// positions whose values form an interval splits into two stacked intervals.
// ranks of PERM_LEN! or more wrap modulo PERM_LEN!. one rank is taken every
// cycle while req_stall is low, and one result beat leaves for each rank, in
// order. the datapath is a row of single-beat cells: MOD_STEPS restoring
// subtract cells that reduce the rank (one is needed at PERM_LEN = 10),
// PERM_LEN digit cells, PERM_LEN-1 readjust cells and PERM_LEN-1 window
// cells. every cell holds one beat and refills as soon as its neighbor
// takes its beat, so bubbles close up while rsp_stall is high and req_stall
// rises only when every cell is full. rsp_perm_packed holds position zero in
// its lowest nibble and keeps the first ten positions when PERM_LEN is above
// ten.
`include "perm_unrank_simple_check_assert.svh"

module perm_unrank_simple_check
   import pusc_pkg::*;
#(
   parameter int PERM_LEN = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [RANK_W-1:0] req_rank,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PACK_W-1:0] rsp_perm_packed,
   output logic              rsp_is_simple
);

   localparam int MOD_STEPS = mod_steps(PERM_LEN);
   localparam int PACK_N    = (PERM_LEN < PACK_NIB) ? PERM_LEN : PACK_NIB;

   // threshold row of digit cell k: multiples of (PERM_LEN-1-k)!
   function automatic logic [PERM_LEN-2:0][RANK_W:0] thr_row_of(input int k);
      logic [PERM_LEN-2:0][RANK_W:0] row;
      for (int m = 0; m < PERM_LEN - 1; m++) begin
         row[m] = dig_thr(PERM_LEN, k, m + 1);
      end
      return row;
   endfunction

   // rank reduction chain
   logic     mod_valid [0:MOD_STEPS];
   logic     mod_stall [0:MOD_STEPS];
   rank_type mod_rank  [0:MOD_STEPS];

   // digit chain
   logic                           dig_valid [0:PERM_LEN];
   logic                           dig_stall [0:PERM_LEN];
   rank_type                       dig_rem   [0:PERM_LEN];
   logic [PERM_LEN-1:0][VAL_W-1:0] dig_digs  [0:PERM_LEN];

   // readjust chain
   logic                           adj_valid [0:PERM_LEN-1];
   logic                           adj_stall [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0] adj_vals  [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0] adj_cmps  [0:PERM_LEN-1];

   // window chain
   logic                              chk_valid [0:PERM_LEN-1];
   logic                              chk_stall [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0]    chk_perm  [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0]    chk_q     [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0]    chk_mn    [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][VAL_W-1:0]    chk_mx    [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][PERM_LEN-1:0] chk_pre   [0:PERM_LEN-1];
   logic [PERM_LEN-1:0][PERM_LEN-1:0] chk_sr    [0:PERM_LEN-1];
   val_type                           chk_len   [0:PERM_LEN-1];
   logic                              chk_bad   [0:PERM_LEN-1];

   // checking aids
   logic                first_full;
   logic                all_full;
   logic [PERM_LEN-1:0] perm_seen;
   logic                adj_hit;

   // request side enters the reduction chain
   assign mod_valid[0] = req_valid;
   assign req_stall    = mod_stall[0];
   assign mod_rank[0]  = req_rank;

   // subtract n! * 2^s for s from high to low, leaving rank mod n!
   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      localparam rank_type SUB = mod_sub(PERM_LEN, MOD_STEPS - 1 - i);
      pusc_mod_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (mod_valid[i]),
         .up_stall (mod_stall[i]),
         .up_rank  (mod_rank[i]),
         .sub_val  (SUB),
         .dn_valid (mod_valid[i+1]),
         .dn_stall (mod_stall[i+1]),
         .dn_rank  (mod_rank[i+1])
      );
   end

   assign dig_valid[0]         = mod_valid[MOD_STEPS];
   assign mod_stall[MOD_STEPS] = dig_stall[0];
   assign dig_rem[0]           = mod_rank[MOD_STEPS];
   assign dig_digs[0]          = '0;

   // digit k of the factorial-base code, plus one
   for (genvar k = 0; k < PERM_LEN; k++) begin : g_dig
      localparam logic [PERM_LEN-2:0][RANK_W:0] THR_ROW = thr_row_of(k);
      pusc_digit_cell #(
         .PERM_LEN (PERM_LEN)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dig_valid[k]),
         .up_stall (dig_stall[k]),
         .up_rem   (dig_rem[k]),
         .up_digs  (dig_digs[k]),
         .thr      (THR_ROW),
         .dn_valid (dig_valid[k+1]),
         .dn_stall (dig_stall[k+1]),
         .dn_rem   (dig_rem[k+1]),
         .dn_digs  (dig_digs[k+1])
      );
   end

   // readjust: cell t compares each value with the digit t+1 places to its left,
   // position zero starts with a code that never compares low
   assign adj_valid[0]        = dig_valid[PERM_LEN];
   assign dig_stall[PERM_LEN] = adj_stall[0];
   assign adj_vals[0]         = dig_digs[PERM_LEN];
   assign adj_cmps[0]         = {dig_digs[PERM_LEN][PERM_LEN-2:0], VAL_TOP};

   for (genvar t = 0; t < PERM_LEN - 1; t++) begin : g_adj
      pusc_adjust_cell #(
         .PERM_LEN (PERM_LEN)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (adj_valid[t]),
         .up_stall (adj_stall[t]),
         .up_vals  (adj_vals[t]),
         .up_cmps  (adj_cmps[t]),
         .dn_valid (adj_valid[t+1]),
         .dn_stall (adj_stall[t+1]),
         .dn_vals  (adj_vals[t+1]),
         .dn_cmps  (adj_cmps[t+1])
      );
   end

   // windows start at length one: min and max are the value itself, the only
   // prefix and the only suffix are single positions, q holds the next value
   assign chk_valid[0]          = adj_valid[PERM_LEN-1];
   assign adj_stall[PERM_LEN-1] = chk_stall[0];
   assign chk_perm[0]           = adj_vals[PERM_LEN-1];
   assign chk_q[0]              = {VAL_NONE, adj_vals[PERM_LEN-1][PERM_LEN-1:1]};
   assign chk_mn[0]             = adj_vals[PERM_LEN-1];
   assign chk_mx[0]             = adj_vals[PERM_LEN-1];
   assign chk_pre[0]            = {PERM_LEN{PERM_LEN'(1)}};
   assign chk_sr[0]             = {PERM_LEN{PERM_LEN'(1)}};
   assign chk_len[0]            = val_type'(1);
   assign chk_bad[0]            = 1'b0;

   // cell w handles windows of length w+2
   for (genvar w = 0; w < PERM_LEN - 1; w++) begin : g_chk
      pusc_check_cell #(
         .PERM_LEN (PERM_LEN)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chk_valid[w]),
         .up_stall (chk_stall[w]),
         .up_perm  (chk_perm[w]),
         .up_q     (chk_q[w]),
         .up_mn    (chk_mn[w]),
         .up_mx    (chk_mx[w]),
         .up_pre   (chk_pre[w]),
         .up_sr    (chk_sr[w]),
         .up_len   (chk_len[w]),
         .up_bad   (chk_bad[w]),
         .dn_valid (chk_valid[w+1]),
         .dn_stall (chk_stall[w+1]),
         .dn_perm  (chk_perm[w+1]),
         .dn_q     (chk_q[w+1]),
         .dn_mn    (chk_mn[w+1]),
         .dn_mx    (chk_mx[w+1]),
         .dn_pre   (chk_pre[w+1]),
         .dn_sr    (chk_sr[w+1]),
         .dn_len   (chk_len[w+1]),
         .dn_bad   (chk_bad[w+1])
      );
   end

   // the last window cell is the output register
   assign rsp_valid              = chk_valid[PERM_LEN-1];
   assign chk_stall[PERM_LEN-1]  = rsp_stall;
   assign rsp_is_simple          = ~chk_bad[PERM_LEN-1];

   always_comb begin
      rsp_perm_packed = '0;
      for (int i = 0; i < PACK_N; i++) begin
         rsp_perm_packed[i*VAL_W +: VAL_W] = chk_perm[PERM_LEN-1][i];
      end
   end

   // first cell of the row, used to check that an accepted beat lands
   if (MOD_STEPS > 0) begin : g_first_mod
      assign first_full = mod_valid[1];
   end else begin : g_first_dig
      assign first_full = dig_valid[1];
   end

   always_comb begin
      all_full = 1'b1;
      for (int i = 1; i <= MOD_STEPS; i++) begin
         all_full = all_full & mod_valid[i];
      end
      for (int i = 1; i <= PERM_LEN; i++) begin
         all_full = all_full & dig_valid[i];
      end
      for (int i = 1; i < PERM_LEN; i++) begin
         all_full = all_full & adj_valid[i] & chk_valid[i];
      end
   end

   // every value 1..PERM_LEN shows up once in a finished result
   always_comb begin
      perm_seen = '0;
      adj_hit   = 1'b0;
      for (int i = 0; i < PERM_LEN; i++) begin
         if ((chk_perm[PERM_LEN-1][i] != VAL_NONE) &&
             (chk_perm[PERM_LEN-1][i] <= val_type'(PERM_LEN))) begin
            perm_seen = perm_seen |
                        (PERM_LEN'(1) << (chk_perm[PERM_LEN-1][i] - val_type'(1)));
         end
      end
      for (int i = 0; i < PERM_LEN - 1; i++) begin
         if ((chk_perm[PERM_LEN-1][i+1] == chk_perm[PERM_LEN-1][i] + val_type'(1)) ||
             (chk_perm[PERM_LEN-1][i] == chk_perm[PERM_LEN-1][i+1] + val_type'(1))) begin
            adj_hit = 1'b1;
         end
      end
   end

   `PUSC_ASSERT_NOW(a_perm_complete, clock, reset, rsp_valid, perm_seen == '1, "result is not a permutation")
   `PUSC_ASSERT_NOW(a_adjacent_not_simple, clock, reset, rsp_valid && adj_hit, !rsp_is_simple, "adjacent consecutive values flagged simple")
   `PUSC_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, all_full && rsp_stall, "input stalled with a free cell")
   `PUSC_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, first_full, "accepted rank did not enter the first cell")

endmodule
